/* src/pct_pkg.sv */
// Package for the proximity contact table: shared types, status codes and
// register indexes. No dependencies.
package pct_pkg;

   localparam int unsigned AddrWidth = 48;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned SlotWidth = 6;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CsrNearWindow  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrCloseMinAge = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrCloseHold   = 2'd2;

   localparam logic [StatusWidth-1:0] StAddedNear   = 3'd0;
   localparam logic [StatusWidth-1:0] StTooEarly    = 3'd1;
   localparam logic [StatusWidth-1:0] StPromoted    = 3'd2;
   localparam logic [StatusWidth-1:0] StAlreadyClose = 3'd3;
   localparam logic [StatusWidth-1:0] StNearFull    = 3'd4;
   localparam logic [StatusWidth-1:0] StCloseFull   = 3'd5;

   // One queued transaction between front and back
   typedef struct packed {
      logic                 kind;
      logic [AddrWidth-1:0] addr;
      logic [TimeWidth-1:0] now;
      logic [SlotWidth-1:0] rslot;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_NEAR_SCAN,
      BK_NEAR_DONE,
      BK_CLOSE_SCAN,
      BK_CLOSE_DONE,
      BK_READ,
      BK_READ_DONE
   } back_state_type;

endpackage

/* src/pct_front.sv */
// Front end of the proximity contact table: accepts commands and holds them
// in a two-entry queue toward the back end. Depends on pct_pkg.
module pct_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  pct_pkg::cmd_type req_cmd,
   output logic             req_full,
   output logic             q_valid,
   output pct_pkg::cmd_type q_cmd,
   input  logic             q_pop
);

   pct_pkg::cmd_type buf_ff [2];
   logic             rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;

   assign push     = req_valid && (count_ff != 2'd2);
   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_cmd    = buf_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, (q_pop && q_valid)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

/* src/pct_back.sv */
// Back end of the proximity contact table: walks the near and close tables one
// slot a cycle to expire, match and store, and serves reads. Depends on pct_pkg.
module pct_back #(
   parameter int unsigned NEAR_DEPTH  = 32,
   parameter int unsigned CLOSE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pct_pkg::TimeWidth-1:0]    near_window,
   input  logic [pct_pkg::TimeWidth-1:0]    close_min_age,
   input  logic [pct_pkg::TimeWidth-1:0]    close_hold,
   input  logic                             q_valid,
   input  pct_pkg::cmd_type                 q_cmd,
   output logic                             q_pop,
   output logic                             rsp_strobe,
   output logic [pct_pkg::StatusWidth-1:0]  rsp_status,
   output logic [pct_pkg::SlotWidth-1:0]    rsp_slot,
   output logic [pct_pkg::AddrWidth-1:0]    rsp_entry_addr,
   output logic                             rsp_entry_valid
);

   localparam int unsigned NW = $clog2(NEAR_DEPTH);
   localparam int unsigned CW = $clog2(CLOSE_DEPTH);
   localparam int unsigned AW = pct_pkg::AddrWidth;
   localparam int unsigned TW = pct_pkg::TimeWidth;
   localparam int unsigned SW = pct_pkg::SlotWidth;

   // Memories
   logic [AW-1:0] near_addr_mem  [NEAR_DEPTH];
   logic [TW-1:0] near_stamp_mem [NEAR_DEPTH];
   logic [AW-1:0] close_addr_mem  [CLOSE_DEPTH];
   logic [TW-1:0] close_stamp_mem [CLOSE_DEPTH];
   logic [NEAR_DEPTH-1:0]  near_live_ff;
   logic [CLOSE_DEPTH-1:0] close_live_ff;

   pct_pkg::back_state_type state_ff, state_in;
   pct_pkg::cmd_type        cmd_ff;
   logic [NW-1:0] nidx_ff, nidx_in;
   logic [CW-1:0] cidx_ff, cidx_in;
   logic [AW-1:0] n_rd_addr_ff, c_rd_addr_ff;
   logic [TW-1:0] n_rd_stamp_ff, c_rd_stamp_ff;
   logic          rd_pend_ff;
   logic [NW-1:0] n_pos_ff;
   logic [CW-1:0] c_pos_ff;
   logic          n_hit_ff, n_free_ok_ff, c_hit_ff, c_free_ok_ff;
   logic [NW-1:0] n_hit_idx_ff, n_free_idx_ff;
   logic [CW-1:0] c_hit_idx_ff, c_free_idx_ff;
   logic [TW-1:0] n_hit_stamp_ff;
   logic          c_want_ff;
   logic          n_last, c_last;
   logic          n_live_eff, c_live_eff;
   logic [TW-1:0] n_age, c_age;
   logic          strobe_ff;
   logic [pct_pkg::StatusWidth-1:0] status_ff;
   logic [SW-1:0] slot_ff;
   logic [AW-1:0] eaddr_ff;
   logic          evalid_ff;
   logic          rd_in_range;

   assign n_last = (nidx_ff == NW'(NEAR_DEPTH - 1));
   assign c_last = (cidx_ff == CW'(CLOSE_DEPTH - 1));
   assign q_pop  = (state_ff == pct_pkg::BK_IDLE) && q_valid;
   assign rd_in_range = ({{(32-SW){1'b0}}, cmd_ff.rslot} < 32'(CLOSE_DEPTH));

   // Ages of the entries read in the previous cycle (n_pos/c_pos)
   assign n_age = cmd_ff.now - n_rd_stamp_ff;
   assign c_age = cmd_ff.now - c_rd_stamp_ff;
   assign n_live_eff = near_live_ff[n_pos_ff] && (n_age <= near_window);
   assign c_live_eff = close_live_ff[c_pos_ff] && (c_age <= close_hold);

   // Next state; every sighting sweeps the close table for expiry
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pct_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = q_cmd.kind ? pct_pkg::BK_READ : pct_pkg::BK_NEAR_SCAN;
            end
         end
         pct_pkg::BK_NEAR_SCAN: begin
            if (rd_pend_ff && (n_pos_ff == NW'(NEAR_DEPTH - 1))) begin
               state_in = pct_pkg::BK_NEAR_DONE;
            end
         end
         pct_pkg::BK_NEAR_DONE:  state_in = pct_pkg::BK_CLOSE_SCAN;
         pct_pkg::BK_CLOSE_SCAN: begin
            if (rd_pend_ff && (c_pos_ff == CW'(CLOSE_DEPTH - 1))) begin
               state_in = pct_pkg::BK_CLOSE_DONE;
            end
         end
         pct_pkg::BK_CLOSE_DONE: state_in = pct_pkg::BK_IDLE;
         pct_pkg::BK_READ:       state_in = pct_pkg::BK_READ_DONE;
         pct_pkg::BK_READ_DONE:  state_in = pct_pkg::BK_IDLE;
         default:                state_in = pct_pkg::BK_IDLE;
      endcase
   end

   // Scan indexes
   always_comb begin
      nidx_in = nidx_ff;
      cidx_in = cidx_ff;
      unique case (state_ff)
         pct_pkg::BK_IDLE: begin
            nidx_in = '0;
            cidx_in = '0;
         end
         pct_pkg::BK_NEAR_SCAN: if (!n_last) nidx_in = nidx_ff + 1'b1;
         pct_pkg::BK_CLOSE_SCAN: if (!c_last) cidx_in = cidx_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pct_pkg::BK_IDLE;
         near_live_ff  <= '0;
         close_live_ff <= '0;
         strobe_ff     <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= 1'b0;
         unique case (state_ff)
            pct_pkg::BK_IDLE: begin
               rd_pend_ff <= 1'b0;
            end
            pct_pkg::BK_NEAR_SCAN: begin
               rd_pend_ff <= !(rd_pend_ff && (n_pos_ff == NW'(NEAR_DEPTH - 1)));
               // Drop expired near entry
               if (rd_pend_ff && near_live_ff[n_pos_ff] && (n_age > near_window)) begin
                  near_live_ff[n_pos_ff] <= 1'b0;
               end
            end
            pct_pkg::BK_NEAR_DONE: begin
               rd_pend_ff <= 1'b0;
               if (!n_hit_ff) begin
                  strobe_ff <= 1'b1;
                  if (n_free_ok_ff) begin
                     near_live_ff[n_free_idx_ff] <= 1'b1;
                  end
               end else if ((cmd_ff.now - n_hit_stamp_ff) < close_min_age) begin
                  strobe_ff <= 1'b1;
               end
            end
            pct_pkg::BK_CLOSE_SCAN: begin
               rd_pend_ff <= !(rd_pend_ff && (c_pos_ff == CW'(CLOSE_DEPTH - 1)));
               // Drop expired close entry
               if (rd_pend_ff && close_live_ff[c_pos_ff] && (c_age > close_hold)) begin
                  close_live_ff[c_pos_ff] <= 1'b0;
               end
            end
            pct_pkg::BK_CLOSE_DONE: begin
               if (c_want_ff) begin
                  strobe_ff <= 1'b1;
                  if (!c_hit_ff && c_free_ok_ff) begin
                     close_live_ff[c_free_idx_ff] <= 1'b1;
                  end
               end
            end
            pct_pkg::BK_READ_DONE: strobe_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // Scan datapath: read one entry a cycle, classify it the next
   always_ff @(posedge clock) begin
      nidx_ff <= nidx_in;
      cidx_ff <= cidx_in;
      n_pos_ff <= nidx_ff;
      n_rd_addr_ff  <= near_addr_mem[nidx_ff];
      n_rd_stamp_ff <= near_stamp_mem[nidx_ff];
      if (state_ff == pct_pkg::BK_READ) begin
         c_rd_addr_ff  <= close_addr_mem[CW'(cmd_ff.rslot)];
         c_rd_stamp_ff <= close_stamp_mem[CW'(cmd_ff.rslot)];
         c_pos_ff      <= CW'(cmd_ff.rslot);
      end else begin
         c_rd_addr_ff  <= close_addr_mem[cidx_ff];
         c_rd_stamp_ff <= close_stamp_mem[cidx_ff];
         c_pos_ff      <= cidx_ff;
      end
      unique case (state_ff)
         pct_pkg::BK_IDLE: begin
            if (q_valid) cmd_ff <= q_cmd;
            n_hit_ff <= 1'b0;
            n_free_ok_ff <= 1'b0;
            c_hit_ff <= 1'b0;
            c_free_ok_ff <= 1'b0;
         end
         pct_pkg::BK_NEAR_SCAN: begin
            if (rd_pend_ff) begin
               if (n_live_eff) begin
                  if (!n_hit_ff && (n_rd_addr_ff == cmd_ff.addr)) begin
                     n_hit_ff       <= 1'b1;
                     n_hit_idx_ff   <= n_pos_ff;
                     n_hit_stamp_ff <= n_rd_stamp_ff;
                  end
               end else if (!n_free_ok_ff) begin
                  n_free_ok_ff  <= 1'b1;
                  n_free_idx_ff <= n_pos_ff;
               end
            end
         end
         pct_pkg::BK_NEAR_DONE: begin
            // Close lookup only for an old enough repeat sighting
            c_want_ff <= n_hit_ff && !((cmd_ff.now - n_hit_stamp_ff) < close_min_age);
            if (!n_hit_ff) begin
               status_ff <= n_free_ok_ff ? pct_pkg::StAddedNear : pct_pkg::StNearFull;
               slot_ff   <= n_free_ok_ff ? SW'(n_free_idx_ff) : '0;
            end else begin
               status_ff <= pct_pkg::StTooEarly;
               slot_ff   <= SW'(n_hit_idx_ff);
            end
            eaddr_ff  <= '0;
            evalid_ff <= 1'b0;
         end
         pct_pkg::BK_CLOSE_SCAN: begin
            if (rd_pend_ff) begin
               if (c_live_eff) begin
                  if (!c_hit_ff && (c_rd_addr_ff == cmd_ff.addr)) begin
                     c_hit_ff     <= 1'b1;
                     c_hit_idx_ff <= c_pos_ff;
                  end
               end else if (!c_free_ok_ff) begin
                  c_free_ok_ff  <= 1'b1;
                  c_free_idx_ff <= c_pos_ff;
               end
            end
         end
         pct_pkg::BK_CLOSE_DONE: begin
            if (c_want_ff) begin
               if (c_hit_ff) begin
                  status_ff <= pct_pkg::StAlreadyClose;
                  slot_ff   <= SW'(c_hit_idx_ff);
               end else if (c_free_ok_ff) begin
                  status_ff <= pct_pkg::StPromoted;
                  slot_ff   <= SW'(c_free_idx_ff);
               end else begin
                  status_ff <= pct_pkg::StCloseFull;
                  slot_ff   <= '0;
               end
               eaddr_ff  <= '0;
               evalid_ff <= 1'b0;
            end
         end
         pct_pkg::BK_READ_DONE: begin
            status_ff <= pct_pkg::StAddedNear;
            slot_ff   <= cmd_ff.rslot;
            if (rd_in_range && close_live_ff[c_pos_ff] && (c_age <= close_hold)) begin
               eaddr_ff  <= c_rd_addr_ff;
               evalid_ff <= 1'b1;
            end else begin
               eaddr_ff  <= '0;
               evalid_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Table writes
   always_ff @(posedge clock) begin
      if (state_ff == pct_pkg::BK_NEAR_DONE && !n_hit_ff && n_free_ok_ff) begin
         near_addr_mem[n_free_idx_ff]  <= cmd_ff.addr;
         near_stamp_mem[n_free_idx_ff] <= cmd_ff.now;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pct_pkg::BK_CLOSE_DONE && c_want_ff && !c_hit_ff && c_free_ok_ff) begin
         close_addr_mem[c_free_idx_ff]  <= cmd_ff.addr;
         close_stamp_mem[c_free_idx_ff] <= cmd_ff.now;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_addr  = eaddr_ff;
   assign rsp_entry_valid = evalid_ff;

endmodule

/* src/proximity_contact_table_core.sv */
// Top level of the proximity contact table: control registers, command queue
// and table engine. Depends on pct_pkg, pct_front and pct_back.
//
//   channel | ports                          | handshake
//   req     | start, busy, req_*             | accepted when start && !busy
//   rsp     | rsp_strobe, rsp_*              | one cycle per result, no stall
//   csr     | csr_write, csr_index, csr_data | written when csr_write is high
//
// Every sighting sweeps both tables for expiry and holds the engine until both
// sweeps are done. Its result strobes after the near sweep, or after the close
// sweep when the close table is looked up; a read passes through the READ and
// READ_DONE states and strobes after them. The scan reads one table slot a cycle
// from each memory port. Reset clears live bits at once. busy rises when the
// two-entry command queue is full; results never stall.
module proximity_contact_table_core #(
   parameter int unsigned NEAR_DEPTH  = 32,
   parameter int unsigned CLOSE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [pct_pkg::AddrWidth-1:0]      req_device_addr,
   input  logic [pct_pkg::TimeWidth-1:0]      req_now_time,
   input  logic [pct_pkg::SlotWidth-1:0]      req_read_slot,
   output logic                               rsp_strobe,
   output logic [pct_pkg::StatusWidth-1:0]    rsp_status,
   output logic [pct_pkg::SlotWidth-1:0]      rsp_slot,
   output logic [pct_pkg::AddrWidth-1:0]      rsp_entry_addr,
   output logic                               rsp_entry_valid,
   input  logic                               csr_write,
   input  logic [pct_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [pct_pkg::TimeWidth-1:0]      csr_data
);

   logic [pct_pkg::TimeWidth-1:0] near_window_ff, close_min_age_ff, close_hold_ff;
   pct_pkg::cmd_type req_cmd, q_cmd;
   logic q_valid, q_pop;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_window_ff   <= 32'd12;
         close_min_age_ff <= 32'd3;
         close_hold_ff    <= 32'd12096;
      end else if (csr_write) begin
         case (csr_index)
            pct_pkg::CsrNearWindow:  near_window_ff   <= csr_data;
            pct_pkg::CsrCloseMinAge: close_min_age_ff <= csr_data;
            pct_pkg::CsrCloseHold:   close_hold_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_cmd = '{kind: req_kind, addr: req_device_addr, now: req_now_time,
                      rslot: req_read_slot};

   pct_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(start),
      .req_cmd  (req_cmd),
      .req_full (busy),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   pct_back #(
      .NEAR_DEPTH (NEAR_DEPTH),
      .CLOSE_DEPTH(CLOSE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .near_window    (near_window_ff),
      .close_min_age  (close_min_age_ff),
      .close_hold     (close_hold_ff),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_entry_addr (rsp_entry_addr),
      .rsp_entry_valid(rsp_entry_valid)
   );

endmodule

/* src/pct_checker.sv */
// Port checker for the proximity contact table core, bound to the top level.
// Depends on pct_pkg.
module pct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [pct_pkg::StatusWidth-1:0] rsp_status,
   input logic [pct_pkg::SlotWidth-1:0]   rsp_slot,
   input logic [pct_pkg::AddrWidth-1:0]   rsp_entry_addr,
   input logic                            rsp_entry_valid
);

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status <= pct_pkg::StCloseFull))
      else $error("status out of range");

   // Only a live read shows an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_entry_valid) |-> (rsp_entry_addr == '0))
      else $error("address without valid entry");

   // Dropped sightings report slot zero
   a_drop_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == pct_pkg::StNearFull ||
                      rsp_status == pct_pkg::StCloseFull)) |-> (rsp_slot == '0))
      else $error("dropped transaction reports slot");

   // Queue fills only through an accepted transaction
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy without accepted transaction");

   // No result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result after reset");

endmodule

bind proximity_contact_table_core pct_checker u_pct_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_slot       (rsp_slot),
   .rsp_entry_addr (rsp_entry_addr),
   .rsp_entry_valid(rsp_entry_valid)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for proximity_contact_table_core: directed table, then
// randomized sighting and read phases under several register settings.
// Depends on pct_pkg and the RTL of the core.
module testbench;

   localparam int NearDepth  = 32;
   localparam int CloseDepth = 64;

   typedef logic [pct_pkg::AddrWidth-1:0]   addr_type;
   typedef logic [pct_pkg::TimeWidth-1:0]   stamp_type;
   typedef logic [pct_pkg::SlotWidth-1:0]   slot_type;
   typedef logic [pct_pkg::StatusWidth-1:0] status_type;

   typedef struct {
      status_type status;
      slot_type   slot;
      addr_type   entry_addr;
      logic       entry_valid;
   } outcome_type;

   typedef struct {
      logic        kind;
      addr_type    addr;
      stamp_type   now;
      slot_type    rslot;
      logic        typed;
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   addr_type req_device_addr = '0;
   stamp_type req_now_time = '0;
   slot_type req_read_slot = '0;
   logic rsp_strobe;
   status_type rsp_status;
   slot_type rsp_slot;
   addr_type rsp_entry_addr;
   logic rsp_entry_valid;
   logic csr_write = 1'b0;
   logic [pct_pkg::CsrIdxWidth-1:0] csr_index = '0;
   stamp_type csr_data = '0;

   proximity_contact_table_core dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the tables and registers
   stamp_type near_window_q, close_min_age_q, close_hold_q;
   addr_type  near_addr_q[NearDepth];
   stamp_type near_stamp_q[NearDepth];
   logic      near_live_q[NearDepth];
   addr_type  close_addr_q[CloseDepth];
   stamp_type close_stamp_q[CloseDepth];
   logic      close_live_q[CloseDepth];
   logic      close_written[CloseDepth];

   outcome_type pending_results[$];
   int mismatches = 0;
   stamp_type clock_now = '0;
   addr_type addr_pool[256];
   row_type directed_rows[$];

   function automatic outcome_type contact_outcome(logic kind, addr_type addr,
                                                   stamp_type now, slot_type rslot);
      outcome_type o;
      int near_hit, near_free, close_hit, close_free;
      o = '{pct_pkg::StAddedNear, '0, '0, 1'b0};
      near_hit = -1; near_free = -1; close_hit = -1; close_free = -1;
      if (kind) begin
         o.slot = rslot;
         if (rslot < CloseDepth && close_live_q[rslot] &&
             stamp_type'(now - close_stamp_q[rslot]) <= close_hold_q) begin
            o.entry_addr = close_addr_q[rslot];
            o.entry_valid = 1'b1;
         end
         return o;
      end
      // expire stale entries first
      for (int k = 0; k < NearDepth; k++)
         if (near_live_q[k] && stamp_type'(now - near_stamp_q[k]) > near_window_q)
            near_live_q[k] = 1'b0;
      for (int k = 0; k < CloseDepth; k++)
         if (close_live_q[k] && stamp_type'(now - close_stamp_q[k]) > close_hold_q)
            close_live_q[k] = 1'b0;
      for (int k = 0; k < NearDepth; k++) begin
         if (near_live_q[k]) begin
            if (near_hit < 0 && near_addr_q[k] == addr) near_hit = k;
         end else if (near_free < 0) begin
            near_free = k;
         end
      end
      if (near_hit < 0) begin
         if (near_free < 0) begin
            o.status = pct_pkg::StNearFull;
         end else begin
            near_addr_q[near_free] = addr;
            near_stamp_q[near_free] = now;
            near_live_q[near_free] = 1'b1;
            o.slot = slot_type'(near_free);
         end
         return o;
      end
      if (stamp_type'(now - near_stamp_q[near_hit]) < close_min_age_q) begin
         o.status = pct_pkg::StTooEarly;
         o.slot = slot_type'(near_hit);
         return o;
      end
      for (int k = 0; k < CloseDepth; k++) begin
         if (close_live_q[k]) begin
            if (close_hit < 0 && close_addr_q[k] == addr) close_hit = k;
         end else if (close_free < 0) begin
            close_free = k;
         end
      end
      if (close_hit >= 0) begin
         o.status = pct_pkg::StAlreadyClose;
         o.slot = slot_type'(close_hit);
      end else if (close_free < 0) begin
         o.status = pct_pkg::StCloseFull;
      end else begin
         close_addr_q[close_free] = addr;
         close_stamp_q[close_free] = now;
         close_live_q[close_free] = 1'b1;
         close_written[close_free] = 1'b1;
         o.status = pct_pkg::StPromoted;
         o.slot = slot_type'(close_free);
      end
      return o;
   endfunction

   // Present one transaction, hold until accepted, then idle a random gap
   task automatic issue(logic kind, addr_type addr, stamp_type now, slot_type rslot,
                        logic typed, outcome_type want);
      outcome_type o;
      int gap;
      start <= 1'b1;
      req_kind <= kind;
      req_device_addr <= addr;
      req_now_time <= now;
      req_read_slot <= rslot;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      o = contact_outcome(kind, addr, now, rslot);
      pending_results.push_back(typed ? want : o);
      @(posedge clock);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain outstanding results and the trailing table sweep, then write one register
   task automatic write_reg(logic [pct_pkg::CsrIdxWidth-1:0] idx, stamp_type value);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CloseDepth + 8) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         pct_pkg::CsrNearWindow:  near_window_q = value;
         pct_pkg::CsrCloseMinAge: close_min_age_q = value;
         pct_pkg::CsrCloseHold:   close_hold_q = value;
         default: ;
      endcase
   endtask

   // Random phase: addresses from a small pool so repeats and promotions occur
   task automatic run_phase(int count, int pool_size, int step_max, int read_pct);
      outcome_type none;
      slot_type rs;
      logic found;
      none = '{pct_pkg::StAddedNear, '0, '0, 1'b0};
      for (int i = 0; i < pool_size; i++)
         addr_pool[i] = addr_type'({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         clock_now = clock_now + $urandom_range(0, step_max);
         if ($urandom_range(0, 49) == 0) clock_now = clock_now + $urandom;
         found = 1'b0;
         if ($urandom_range(0, 99) < read_pct) begin
            // read only slots that have held an entry
            for (int t = 0; t < 16 && !found; t++) begin
               rs = slot_type'($urandom_range(0, CloseDepth - 1));
               found = close_written[rs];
            end
         end
         if (found)
            issue(1'b1, addr_type'({$urandom, $urandom}), clock_now, rs, 1'b0, none);
         else
            issue(1'b0, ($urandom_range(0, 19) == 0) ? addr_type'({$urandom, $urandom})
                  : addr_pool[$urandom_range(0, pool_size - 1)],
                  clock_now, slot_type'($urandom), 1'b0, none);
      end
   endtask

   function automatic row_type mk(logic kind, addr_type addr, stamp_type now, slot_type rs,
                                  logic typed, status_type st,
                                  slot_type sl, addr_type ea, logic ev);
      row_type r;
      r.kind = kind; r.addr = addr; r.now = now; r.rslot = rs;
      r.typed = typed;
      r.want = '{st, sl, ea, ev};
      return r;
   endfunction

   // Compare each strobed result against the oldest expectation
   always @(negedge clock) begin
      outcome_type w;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d slot=%0d",
                                           rsp_status, rsp_slot);
         end else begin
            w = pending_results.pop_front();
            if (rsp_status !== w.status || rsp_slot !== w.slot ||
                rsp_entry_addr !== w.entry_addr || rsp_entry_valid !== w.entry_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d sl=%0d a=%h v=%b  got st=%0d sl=%0d a=%h v=%b",
                           w.status, w.slot, w.entry_addr, w.entry_valid, rsp_status,
                           rsp_slot, rsp_entry_addr, rsp_entry_valid);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      near_window_q = 12; close_min_age_q = 3; close_hold_q = 12096;
      for (int k = 0; k < NearDepth; k++) near_live_q[k] = 1'b0;
      for (int k = 0; k < CloseDepth; k++) begin
         close_live_q[k] = 1'b0;
         close_written[k] = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of address, the added, too-early, promoted and already-close statuses, read paths, expiry
      directed_rows.push_back(mk(0, '0, 0, 0, 1, pct_pkg::StAddedNear, 0, '0, 0));
      directed_rows.push_back(mk(0, '1, 0, 0, 1, pct_pkg::StAddedNear, 1, '0, 0));
      directed_rows.push_back(mk(0, '0, 1, 0, 1, pct_pkg::StTooEarly, 0, '0, 0));
      directed_rows.push_back(mk(0, '0, 3, 0, 1, pct_pkg::StPromoted, 0, '0, 0));
      directed_rows.push_back(mk(0, '0, 4, 0, 1, pct_pkg::StAlreadyClose, 0, '0, 0));
      directed_rows.push_back(mk(1, '1, 4, 0, 1, pct_pkg::StAddedNear, 0, '0, 1));
      directed_rows.push_back(mk(0, '1, 5, 0, 1, pct_pkg::StPromoted, 1, '0, 0));
      directed_rows.push_back(mk(1, '0, 6, 1, 1, pct_pkg::StAddedNear, 1, '1, 1));
      directed_rows.push_back(mk(0, '0, 20, 0, 0, '0, 0, '0, 0));
      directed_rows.push_back(mk(1, '0, 12099, 0, 0, '0, 0, '0, 0));
      directed_rows.push_back(mk(1, '0, 12100, 0, 1, pct_pkg::StAddedNear, 0, '0, 0));
      directed_rows.push_back(mk(0, 48'h5555_5555_5555, 32'hFFFF_FFFE, 0, 0, '0, 0, '0, 0));
      directed_rows.push_back(mk(0, 48'h5555_5555_5555, 32'h0000_0002, 0, 0, '0, 0, '0, 0));
      directed_rows.push_back(mk(0, 48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF, 0, 0, '0, 0, '0, 0));
      foreach (directed_rows[i])
         issue(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].now,
               directed_rows[i].rslot, directed_rows[i].typed, directed_rows[i].want);

      // Reset settings, moderate churn
      clock_now = 32'hFFFF_FF00;
      run_phase(150, 24, 2, 20);
      // Long windows, instant promotion: fill near and close tables
      write_reg(pct_pkg::CsrNearWindow, 200);
      write_reg(pct_pkg::CsrCloseMinAge, 0);
      write_reg(pct_pkg::CsrCloseHold, '1);
      run_phase(250, 120, 1, 15);
      // Extremes: everything expires at once, promotion almost never
      write_reg(pct_pkg::CsrNearWindow, 0);
      write_reg(pct_pkg::CsrCloseMinAge, '1);
      write_reg(pct_pkg::CsrCloseHold, 0);
      write_reg(2'd3, $urandom);
      run_phase(100, 8, 1, 20);
      // Nothing expires: near table saturates
      write_reg(pct_pkg::CsrNearWindow, '1);
      write_reg(pct_pkg::CsrCloseMinAge, 2);
      write_reg(pct_pkg::CsrCloseHold, '1);
      run_phase(120, 48, 3, 25);
      // Short close hold so close slots are freed and reused
      write_reg(pct_pkg::CsrNearWindow, 30);
      write_reg(pct_pkg::CsrCloseMinAge, 5);
      write_reg(pct_pkg::CsrCloseHold, 40);
      run_phase(220, 40, 3, 25);

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* sim.f */
src/pct_pkg.sv
src/pct_front.sv
src/pct_back.sv
src/proximity_contact_table_core.sv
src/pct_checker.sv
bench/testbench.sv
